>>> src/fde_pkg.sv
// ----------------------------------------------------------------------------
// fde_pkg: shared definitions for the fraction decimal expansion block
// Operand widths, digit limits, controller states and divider request types.
// ----------------------------------------------------------------------------
package fde_pkg;

    localparam int OPERAND_BITS        = 31;
    localparam int MAX_FRACTION_DIGITS = 63;

    // Width of the fraction digit count and of the divider step counter.
    localparam int DIGITS_W = $clog2(MAX_FRACTION_DIGITS + 1);
    localparam int CNT_W    = $clog2(OPERAND_BITS + 1);

    // A remainder times ten needs four more bits than the remainder.
    localparam int REM10_W     = OPERAND_BITS + 4;
    // A decimal digit is at most nine, so four quotient bits suffice.
    localparam int DIGIT_STEPS = 4;

    localparam int IN_FIELDS_W  = 2 * OPERAND_BITS + DIGITS_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = ((OPERAND_BITS + 7) / 8) * 8;
    localparam int OUT_TUSER_W  = 2;

    // Bit positions in the output tuser.
    localparam int TUSER_INT_BIT = 0;
    localparam int TUSER_ERR_BIT = 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_PUT
    } t_state;

    typedef struct packed {
        logic                    start;
        logic [OPERAND_BITS-1:0] rem_init;
        logic [OPERAND_BITS-1:0] dividend;
        logic [CNT_W-1:0]        steps;
        logic [OPERAND_BITS-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                    busy;
        logic                    done;
        logic [OPERAND_BITS-1:0] quot;
        logic [OPERAND_BITS-1:0] rem;
    } t_div_resp;

endpackage

>>> src/fde_divider.sv
// ----------------------------------------------------------------------------
// fde_divider: bit-serial restoring divider
// Shifts one dividend bit into the partial remainder per cycle and develops
// one quotient bit per cycle. The partial remainder must start below the
// divisor; the step count sets how many dividend bits are consumed.
// ----------------------------------------------------------------------------
module fde_divider (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fde_pkg::t_div_req    i_req,
    output fde_pkg::t_div_resp   o_resp
);

    localparam int W = fde_pkg::OPERAND_BITS;

    logic                     r_busy;
    logic                     r_done;
    logic [fde_pkg::CNT_W-1:0] r_cnt;
    logic [W-1:0]             r_p;
    logic [W-1:0]             r_dvd;
    logic [W-1:0]             r_q;
    logic [W-1:0]             r_div;

    logic [W:0]               w_trial;
    logic [W:0]               w_diff;
    logic                     w_ge;
    logic [W-1:0]             w_next_p;

    assign w_trial  = {r_p, r_dvd[W-1]};
    assign w_diff   = w_trial - {1'b0, r_div};
    assign w_ge     = (w_trial >= {1'b0, r_div});
    assign w_next_p = w_ge ? w_diff[W-1:0] : w_trial[W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == fde_pkg::CNT_W'(1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_p   <= i_req.rem_init;
            r_dvd <= i_req.dividend;
            r_q   <= '0;
            r_div <= i_req.divisor;
            r_cnt <= i_req.steps;
        end else if (r_busy) begin
            r_p   <= w_next_p;
            r_dvd <= {r_dvd[W-2:0], 1'b0};
            r_q   <= {r_q[W-2:0], w_ge};
            r_cnt <= r_cnt - fde_pkg::CNT_W'(1);
        end
    end

    assign o_resp.busy = r_busy;
    assign o_resp.done = r_done;
    assign o_resp.quot = r_q;
    assign o_resp.rem  = r_p;

endmodule

>>> src/fde_ctrl.sv
// ----------------------------------------------------------------------------
// fde_ctrl: request sequencer and result register
// Takes a request, drives the shared divider for the integer part and then
// once per fraction digit, and hands each result to the output register.
// ----------------------------------------------------------------------------
module fde_ctrl (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic [fde_pkg::IN_TDATA_W-1:0]       i_s_tdata,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [fde_pkg::OUT_TDATA_W-1:0]      o_m_tdata,
    output logic                                 o_m_tlast,
    output logic [fde_pkg::OUT_TUSER_W-1:0]      o_m_tuser,
    output fde_pkg::t_div_req                    o_div_req,
    input  fde_pkg::t_div_resp                   i_div_resp
);

    localparam int W  = fde_pkg::OPERAND_BITS;
    localparam int DW = fde_pkg::DIGITS_W;
    localparam int RW = fde_pkg::REM10_W;

    fde_pkg::t_state r_state, n_state;

    logic [W-1:0]  r_den, n_den;
    logic [DW-1:0] r_left, n_left;
    logic          r_is_int, n_is_int;
    logic [RW-1:0] r_rem10, n_rem10;

    logic [W-1:0]  r_pend_digit, n_pend_digit;
    logic          r_pend_int, n_pend_int;
    logic          r_pend_last, n_pend_last;
    logic          r_pend_err, n_pend_err;

    logic          r_out_valid, n_out_valid;
    logic [W-1:0]  r_out_digit, n_out_digit;
    logic          r_out_int, n_out_int;
    logic          r_out_last, n_out_last;
    logic          r_out_err, n_out_err;

    logic [W-1:0]  w_num;
    logic [W-1:0]  w_den;
    logic [DW-1:0] w_want;
    logic [DW-1:0] w_want_sat;
    logic          w_accept;
    logic          w_slot_free;
    logic [RW-1:0] w_rem10;
    logic          w_cand_last;

    assign w_num  = i_s_tdata[W-1:0];
    assign w_den  = i_s_tdata[2*W-1:W];
    assign w_want = i_s_tdata[2*W+DW-1:2*W];
    assign w_want_sat = (w_want > DW'(fde_pkg::MAX_FRACTION_DIGITS)) ?
                        DW'(fde_pkg::MAX_FRACTION_DIGITS) : w_want;

    assign o_s_tready  = (r_state == fde_pkg::ST_IDLE);
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_slot_free = !r_out_valid || i_m_tready;

    // Next long-division dividend: the divider's remainder times ten.
    assign w_rem10 = (RW'(i_div_resp.rem) << 3) + (RW'(i_div_resp.rem) << 1);
    assign w_cand_last = (r_left == '0);

    always_comb begin
        n_state      = r_state;
        n_den        = r_den;
        n_left       = r_left;
        n_is_int     = r_is_int;
        n_rem10      = r_rem10;
        n_pend_digit = r_pend_digit;
        n_pend_int   = r_pend_int;
        n_pend_last  = r_pend_last;
        n_pend_err   = r_pend_err;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_digit  = r_out_digit;
        n_out_int    = r_out_int;
        n_out_last   = r_out_last;
        n_out_err    = r_out_err;

        o_div_req.start    = 1'b0;
        o_div_req.rem_init = r_rem10[RW-1:fde_pkg::DIGIT_STEPS];
        o_div_req.dividend = {r_rem10[fde_pkg::DIGIT_STEPS-1:0],
                              {(W-fde_pkg::DIGIT_STEPS){1'b0}}};
        o_div_req.steps    = fde_pkg::CNT_W'(fde_pkg::DIGIT_STEPS);
        o_div_req.divisor  = r_den;

        unique case (r_state)
            fde_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_den  = w_den;
                    n_left = w_want_sat;
                    if (w_den == '0) begin
                        n_pend_digit = '0;
                        n_pend_int   = 1'b0;
                        n_pend_last  = 1'b1;
                        n_pend_err   = 1'b1;
                        n_state      = fde_pkg::ST_PUT;
                    end else begin
                        o_div_req.start    = 1'b1;
                        o_div_req.rem_init = '0;
                        o_div_req.dividend = w_num;
                        o_div_req.steps    = fde_pkg::CNT_W'(W);
                        o_div_req.divisor  = w_den;
                        n_is_int           = 1'b1;
                        n_state            = fde_pkg::ST_DIV;
                    end
                end
            end
            fde_pkg::ST_DIV: begin
                if (i_div_resp.done) begin
                    if (w_slot_free) begin
                        n_out_valid = 1'b1;
                        n_out_digit = i_div_resp.quot;
                        n_out_int   = r_is_int;
                        n_out_last  = w_cand_last;
                        n_out_err   = 1'b0;
                        if (w_cand_last) begin
                            n_state = fde_pkg::ST_IDLE;
                        end else begin
                            // Launch the next digit straight from the remainder.
                            o_div_req.start    = 1'b1;
                            o_div_req.rem_init = w_rem10[RW-1:fde_pkg::DIGIT_STEPS];
                            o_div_req.dividend = {w_rem10[fde_pkg::DIGIT_STEPS-1:0],
                                                  {(W-fde_pkg::DIGIT_STEPS){1'b0}}};
                            n_left   = r_left - DW'(1);
                            n_is_int = 1'b0;
                        end
                    end else begin
                        n_pend_digit = i_div_resp.quot;
                        n_pend_int   = r_is_int;
                        n_pend_last  = w_cand_last;
                        n_pend_err   = 1'b0;
                        n_rem10      = w_rem10;
                        n_state      = fde_pkg::ST_PUT;
                    end
                end
            end
            fde_pkg::ST_PUT: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_digit = r_pend_digit;
                    n_out_int   = r_pend_int;
                    n_out_last  = r_pend_last;
                    n_out_err   = r_pend_err;
                    if (r_pend_last) begin
                        n_state = fde_pkg::ST_IDLE;
                    end else begin
                        o_div_req.start = 1'b1;
                        n_left          = r_left - DW'(1);
                        n_is_int        = 1'b0;
                        n_state         = fde_pkg::ST_DIV;
                    end
                end
            end
            default: begin
                n_state = fde_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fde_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_den        <= n_den;
        r_left       <= n_left;
        r_is_int     <= n_is_int;
        r_rem10      <= n_rem10;
        r_pend_digit <= n_pend_digit;
        r_pend_int   <= n_pend_int;
        r_pend_last  <= n_pend_last;
        r_pend_err   <= n_pend_err;
        r_out_digit  <= n_out_digit;
        r_out_int    <= n_out_int;
        r_out_last   <= n_out_last;
        r_out_err    <= n_out_err;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = fde_pkg::OUT_TDATA_W'(r_out_digit);
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = {r_out_err, r_out_int};

endmodule

>>> src/fraction_decimal_expansion_top.sv
// ----------------------------------------------------------------------------
// fraction_decimal_expansion_top: decimal expansion of a fraction
// Long division of numerator by denominator on a shared bit-serial divider.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream takes one request: numerator, denominator and the number
// of fraction digits. The master stream returns the integer part first
// (tuser bit 0 set), then one decimal digit per item; tlast marks the final
// item of a request. A zero denominator returns a single item with tuser
// bit 1 set, data zero and tlast set.
// The divider retires one quotient bit per cycle, one per dividend bit that
// it consumes: all 31 operand bits for the integer part, which then moves to
// the output register, and four bits for each fraction digit. A new request
// is taken only once the last item of the previous one sits in the output
// register.
// If the receiver stalls, one finished item waits in the output register and
// a second in a holding register; the divider then pauses until room frees.
// A synchronous active-low reset returns the sequencer to idle and empties
// the output register.
// ----------------------------------------------------------------------------
module fraction_decimal_expansion_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // Fields from bit 0: numerator_value, denominator_value, fraction_digits.
    input  logic [fde_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // Fields from bit 0: digit_value.
    output logic [fde_pkg::OUT_TDATA_W-1:0]     o_m_tdata,
    output logic                                o_m_tlast,
    // Fields from bit 0: is_integer_part, divide_error.
    output logic [fde_pkg::OUT_TUSER_W-1:0]     o_m_tuser
);

    fde_pkg::t_div_req  w_div_req;
    fde_pkg::t_div_resp w_div_resp;

    fde_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser),
        .o_div_req  (w_div_req),
        .i_div_resp (w_div_resp)
    );

    fde_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_resp  (w_div_resp)
    );

`ifndef SYNTH
    // A request is never taken while the divider is still working.
    a_accept_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |-> !w_div_resp.busy)
        else $error("request accepted while divider busy");

    // Fraction digits are decimal.
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[fde_pkg::TUSER_INT_BIT]) |->
        (o_m_tdata < fde_pkg::OUT_TDATA_W'(10)))
        else $error("fraction digit out of range");

    // An error item is zero, final and not an integer part.
    a_error_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[fde_pkg::TUSER_ERR_BIT]) |->
        (o_m_tlast && (o_m_tdata == '0) && !o_m_tuser[fde_pkg::TUSER_INT_BIT]))
        else $error("malformed divide error item");

    // The divider is never restarted in the middle of a division.
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_req.start |-> !w_div_resp.busy)
        else $error("divider restarted while busy");
`endif

endmodule

>>> tb/fraction_decimal_expansion_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fraction_decimal_expansion_top_tb: self-checking bench for the expansion
// Drives numerator, denominator and digit count requests into the slave
// stream and checks every output item against a long-division predictor.
// ----------------------------------------------------------------------------
module fraction_decimal_expansion_top_tb;

    localparam int          OPERAND_BITS        = fde_pkg::OPERAND_BITS;
    localparam int          MAX_FRACTION_DIGITS = fde_pkg::MAX_FRACTION_DIGITS;
    localparam int          DIGITS_W            = fde_pkg::DIGITS_W;
    localparam int          REM10_W             = fde_pkg::REM10_W;
    localparam int          IN_TDATA_W          = fde_pkg::IN_TDATA_W;
    localparam int          OUT_TDATA_W         = fde_pkg::OUT_TDATA_W;
    localparam int          OUT_TUSER_W         = fde_pkg::OUT_TUSER_W;
    localparam int          TUSER_INT_BIT       = fde_pkg::TUSER_INT_BIT;
    localparam int          TUSER_ERR_BIT       = fde_pkg::TUSER_ERR_BIT;

    localparam int          DIGIT_BITS     = 31;
    localparam longint      OPERAND_MASK   = (64'd1 << OPERAND_BITS) - 1;
    localparam longint      REM_MASK       = (64'd1 << REM10_W) - 1;
    localparam longint      RADIX          = 10;
    localparam int          RANDOM_ITEMS   = 400;
    localparam int          HOLD_AFTER     = 150;
    localparam int          HOLD_CYCLES    = 600;
    localparam int          DRAIN_CYCLES   = 500;
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          PRINT_CAP      = 30;

    typedef struct {
        bit [OUT_TDATA_W-1:0] digit;
        bit                   is_int;
        bit                   last;
        bit                   err;
        int                   req_id;
        int                   pos;
    } t_digit_result;

    class t_expansion_scoreboard;
        t_digit_result pending[$];
        int unsigned   mismatches;
        int unsigned   requests_seen;
        int unsigned   results_seen;
        int unsigned   error_requests;
        int unsigned   longest_run;

        // Long division of one accepted request into its expected items.
        function void note_request(bit [DIGIT_BITS-1:0] num, bit [DIGIT_BITS-1:0] den,
                                   bit [DIGITS_W-1:0] digits);
            longint unsigned n;
            longint unsigned d;
            longint unsigned rem;
            int              wanted;
            t_digit_result   item;
            n = longint'(num) & OPERAND_MASK;
            d = longint'(den) & OPERAND_MASK;
            wanted = digits;
            if (wanted > MAX_FRACTION_DIGITS) wanted = MAX_FRACTION_DIGITS;
            item.req_id = requests_seen;
            requests_seen++;
            if (d == 0) begin
                item.digit = '0;
                item.is_int = 1'b0;
                item.last = 1'b1;
                item.err = 1'b1;
                item.pos = 0;
                pending.push_back(item);
                error_requests++;
                return;
            end
            item.digit = OUT_TDATA_W'((n / d) & ((64'd1 << DIGIT_BITS) - 1));
            item.is_int = 1'b1;
            item.last = (wanted == 0);
            item.err = 1'b0;
            item.pos = 0;
            pending.push_back(item);
            rem = ((n % d) * RADIX) & REM_MASK;
            for (int k = 1; k <= wanted; k++) begin
                item.digit = OUT_TDATA_W'(rem / d);
                item.is_int = 1'b0;
                item.last = (k == wanted);
                item.pos = k;
                pending.push_back(item);
                rem = ((rem % d) * RADIX) & REM_MASK;
            end
            if (wanted + 1 > longest_run) longest_run = wanted + 1;
        endfunction

        task report_mismatch(string msg);
            if (mismatches < PRINT_CAP) $display("%0t MISMATCH: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_result(logic [OUT_TDATA_W-1:0] data, logic last,
                          logic [OUT_TUSER_W-1:0] user);
            t_digit_result want;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("item with no request pending, data=%0d", data));
                return;
            end
            want = pending.pop_front();
            results_seen++;
            if (data !== want.digit)
                report_mismatch($sformatf("request %0d item %0d: data %0d, wanted %0d",
                                          want.req_id, want.pos, data, want.digit));
            if (last !== want.last)
                report_mismatch($sformatf("request %0d item %0d: tlast %b, wanted %b",
                                          want.req_id, want.pos, last, want.last));
            if (user[TUSER_INT_BIT] !== want.is_int)
                report_mismatch($sformatf("request %0d item %0d: integer flag %b, wanted %b",
                                          want.req_id, want.pos, user[TUSER_INT_BIT],
                                          want.is_int));
            if (user[TUSER_ERR_BIT] !== want.err)
                report_mismatch($sformatf("request %0d item %0d: error flag %b, wanted %b",
                                          want.req_id, want.pos, user[TUSER_ERR_BIT],
                                          want.err));
        endtask
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   o_m_tlast;
    logic [OUT_TUSER_W-1:0] o_m_tuser;

    t_expansion_scoreboard sb = new();
    int unsigned           requests_sent = 0;
    bit                    hold_done = 1'b0;
    int unsigned           idle_cycles = 0;

    fraction_decimal_expansion_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Offers one request, after an optional idle gap, and waits for its accept.
    task send_request(bit [DIGIT_BITS-1:0] num, bit [DIGIT_BITS-1:0] den,
                      bit [DIGITS_W-1:0] digits);
        int pick;
        int gap;
        pick = $urandom_range(0, 99);
        if (pick < 70) gap = 0;
        else if (pick < 95) gap = $urandom_range(1, 3);
        else gap = $urandom_range(20, 60);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= IN_TDATA_W'({digits, den, num});
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        requests_sent++;
    endtask

    // Picks an operand, often shifted down so that small values are common.
    function bit [DIGIT_BITS-1:0] pick_operand();
        bit [DIGIT_BITS-1:0] v;
        v = DIGIT_BITS'($urandom);
        if ($urandom_range(0, 1)) v = v >> $urandom_range(0, DIGIT_BITS - 1);
        return v;
    endfunction

    function bit [DIGITS_W-1:0] pick_digits();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 80) return DIGITS_W'($urandom_range(0, 8));
        if (pick < 95) return DIGITS_W'($urandom_range(9, 32));
        return DIGITS_W'($urandom_range(33, MAX_FRACTION_DIGITS));
    endfunction

    // Receiver: random ready pattern, plus one long hold-off that backs up the block.
    initial begin
        int mode;
        int len;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (requests_sent >= HOLD_AFTER && !hold_done) begin
                hold_done = 1'b1;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            mode = $urandom_range(0, 9);
            if (mode < 4) len = $urandom_range(5, 40);
            else if (mode < 8) len = $urandom_range(1, 20);
            else len = $urandom_range(1, 4);
            repeat (len) begin
                if (mode < 4) i_m_tready <= 1'b1;
                else if (mode < 8) i_m_tready <= 1'($urandom_range(0, 1));
                else if (mode == 8) i_m_tready <= 1'b0;
                else i_m_tready <= 1'b0;
                @(posedge i_clk);
            end
            // Now and then a longer stall.
            if ($urandom_range(0, 19) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(20, 80)) @(posedge i_clk);
            end
        end
    end

    // Monitor: both handshakes are sampled at the clock edge, with the watchdog.
    always @(posedge i_clk) begin
        bit progress;
        progress = 1'b0;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                sb.note_request(i_s_tdata[DIGIT_BITS-1:0],
                                i_s_tdata[2*DIGIT_BITS-1:DIGIT_BITS],
                                i_s_tdata[2*DIGIT_BITS+DIGITS_W-1:2*DIGIT_BITS]);
                progress = 1'b1;
            end
            if (o_m_tvalid && i_m_tready) begin
                sb.check_result(o_m_tdata, o_m_tlast, o_m_tuser);
                progress = 1'b1;
            end
            if (progress) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t watchdog: no handshake for %0d cycles, %0d items pending",
                         $realtime, idle_cycles, sb.pending.size());
                $display("** fraction_decimal_expansion_top: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        bit [DIGIT_BITS-1:0] max_op;
        bit [DIGIT_BITS-1:0] num;
        bit [DIGIT_BITS-1:0] den;
        int                  pick;
        max_op = '1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero denominators, operand extremes, no digits, full digit count,
        // repeating and terminating fractions, alternating bit patterns.
        send_request(0, 0, 0);
        send_request(max_op, 0, MAX_FRACTION_DIGITS);
        send_request(0, 1, 0);
        send_request(max_op, 1, MAX_FRACTION_DIGITS);
        send_request(max_op, max_op, MAX_FRACTION_DIGITS);
        send_request(max_op - 1, max_op, MAX_FRACTION_DIGITS);
        send_request(1, max_op, MAX_FRACTION_DIGITS);
        send_request(1, 3, MAX_FRACTION_DIGITS);
        send_request(22, 7, 20);
        send_request(1, 8, 5);
        send_request(5, 5, 3);
        send_request(7, 2, 1);
        send_request(max_op, 2, 0);
        send_request(1, 7, MAX_FRACTION_DIGITS);
        send_request(0, max_op, 10);
        send_request(31'h5555_5555, 31'h2AAA_AAAA, 6'b101010);
        send_request(31'h2AAA_AAAA, 31'h5555_5555, 6'b010101);
        send_request(123456789, 1000000007, 30);
        send_request(max_op, 3, 7);
        send_request(12345, 0, 5);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            pick = $urandom_range(0, 99);
            num = pick_operand();
            if (pick < 10) begin
                den = '0;
            end else if (pick < 60) begin
                den = DIGIT_BITS'($urandom_range(1, 1000));
            end else begin
                den = pick_operand();
                if (den == 0) den = 1;
            end
            send_request(num, den, pick_digits());
        end
        i_s_tvalid <= 1'b0;

        // Let the monitor record the final request before waiting for the drain.
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests (%0d with zero denominator), %0d output items checked.",
                 sb.requests_seen, sb.error_requests, sb.results_seen);
        $display("Longest expansion was %0d items; one receiver hold-off of %0d cycles.",
                 sb.longest_run, HOLD_CYCLES);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("** fraction_decimal_expansion_top: PASSED **");
        end else begin
            $display("%0d mismatches, %0d items still expected", sb.mismatches,
                     sb.pending.size());
            $display("** fraction_decimal_expansion_top: FAILED **");
        end
        $finish;
    end

endmodule
